FILE: hw/rtl/dual_biquad_notch_filter_assert.svh
// Assertion macros shared by the filter modules.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef DUAL_BIQUAD_NOTCH_FILTER_ASSERT_SVH
`define DUAL_BIQUAD_NOTCH_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

`define DBNF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dual biquad notch filter: same-cycle check failed");

`define DBNF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dual biquad notch filter: next-cycle check failed");

`else

`define DBNF_ASSERT_IMP(label, clk, rst, ante, cons)

`define DBNF_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/dbnf_pkg.sv
`default_nettype none

package dbnf_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int HIST_BITS      = 24;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [1:0] ACT_SAMPLE     = 2'd0;
   localparam logic [1:0] ACT_CLEAR_REC  = 2'd1;
   localparam logic [1:0] ACT_CLEAR_LIVE = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A1 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A2 = 3'd4;

   // Default notch: 50 Hz at a 200 Hz sample rate.
   localparam real NOTCH_B_OUTER = 0.95125;
   localparam real NOTCH_B_MID   = 0.0;
   localparam real NOTCH_A_ONE   = 0.0;
   localparam real NOTCH_A_TWO   = 0.9025;

   typedef struct packed {
      logic [1:0]             action;
      logic [SAMPLE_BITS-1:0] raw_sample;
      logic                   lead_off_pos;
      logic                   lead_off_neg;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] raw_echo;
      logic [SAMPLE_BITS-1:0] recording_value;
      logic [SAMPLE_BITS-1:0] live_value;
      logic                   lead_off_pos_out;
      logic                   lead_off_neg_out;
   } rsp_type;

   typedef struct packed {
      logic load_sample;
      logic load_clear;
      logic step_sample;
      logic step_clear;
   } sec_ctl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/dbnf_section.sv
`default_nettype none

module dbnf_section #(
   parameter int COEF_FRAC_BITS  = 16,
   parameter int STATE_FRAC_BITS = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire dbnf_pkg::sec_ctl_type                 ctl,
   input  wire logic [dbnf_pkg::SAMPLE_BITS-1:0]      sample,
   input  wire logic signed [COEF_FRAC_BITS+1:0]      coef_b0,
   input  wire logic signed [COEF_FRAC_BITS+1:0]      coef_b1,
   input  wire logic signed [COEF_FRAC_BITS+1:0]      coef_b2,
   input  wire logic signed [COEF_FRAC_BITS+1:0]      coef_a1,
   input  wire logic signed [COEF_FRAC_BITS+1:0]      coef_a2,
   output logic [dbnf_pkg::SAMPLE_BITS-1:0]           value
);

   `include "dual_biquad_notch_filter_assert.svh"

   localparam int COEF_W  = COEF_FRAC_BITS + 2;
   localparam int SB      = dbnf_pkg::SAMPLE_BITS;
   localparam int HB      = dbnf_pkg::HIST_BITS;
   localparam int PROD_W  = COEF_W + SB + 1;
   localparam int FF_W    = PROD_W + 2;
   localparam int FB_W    = COEF_W + HB;
   localparam int SUM_W   = (FF_W + STATE_FRAC_BITS > FB_W) ? FF_W + STATE_FRAC_BITS : FB_W;
   localparam int ACC_W   = SUM_W + 2;
   localparam int ROUND_S = COEF_FRAC_BITS;
   localparam int ROUND_O = COEF_FRAC_BITS + STATE_FRAC_BITS;

   localparam logic signed [ACC_W-1:0] ONE      = ACC_W'(1);
   localparam logic signed [ACC_W-1:0] HALF_S   = ONE <<< (ROUND_S - 1);
   localparam logic signed [ACC_W-1:0] HALF_O   = ONE <<< (ROUND_O - 1);
   localparam logic signed [ACC_W-1:0] HIST_MAX = (ONE <<< (HB - 1)) - ONE;
   localparam logic signed [ACC_W-1:0] HIST_MIN = -(ONE <<< (HB - 1));
   localparam logic signed [ACC_W-1:0] OUT_MAX  = (ONE <<< SB) - ONE;

   logic [SB-1:0]            xh0_ff, xh0_in, xh1_ff, xh1_in;
   logic signed [HB-1:0]     yh0_ff, yh0_in, yh1_ff, yh1_in;
   logic signed [PROD_W-1:0] pb0_ff, pb0_in, pb1_ff, pb1_in, pb2_ff, pb2_in;

   logic signed [ACC_W-1:0]  ff_sum, acc, neg_one, sum_s, sum_o, ys_full, yo_full;
   logic signed [FB_W-1:0]   fb1, fb2;
   logic signed [HB-1:0]     ys_sat;

   // Feed-forward products are formed when the sample is transferred in.
   assign pb0_in = coef_b0 * $signed({1'b0, sample});
   assign pb1_in = coef_b1 * $signed({1'b0, xh0_ff});
   assign pb2_in = coef_b2 * $signed({1'b0, xh1_ff});

   always_comb begin
      xh0_in = xh0_ff;
      xh1_in = xh1_ff;
      if (ctl.load_clear) begin
         xh0_in = '0;
         xh1_in = '0;
      end else if (ctl.load_sample) begin
         xh0_in = sample;
         xh1_in = xh0_ff;
      end
   end

   // Feedback closes within the second stage.
   assign fb1     = coef_a1 * yh0_ff;
   assign fb2     = coef_a2 * yh1_ff;
   assign ff_sum  = ACC_W'(pb0_ff) + ACC_W'(pb1_ff) + ACC_W'(pb2_ff);
   assign acc     = (ff_sum <<< STATE_FRAC_BITS) - ACC_W'(fb1) - ACC_W'(fb2);
   assign neg_one = {{(ACC_W-1){1'b0}}, acc[ACC_W-1]};
   assign sum_s   = acc + HALF_S - neg_one;
   assign sum_o   = acc + HALF_O - neg_one;
   assign ys_full = sum_s >>> ROUND_S;
   assign yo_full = sum_o >>> ROUND_O;

   always_comb begin
      if (ys_full > HIST_MAX) begin
         ys_sat = HB'(HIST_MAX);
      end else if (ys_full < HIST_MIN) begin
         ys_sat = HB'(HIST_MIN);
      end else begin
         ys_sat = HB'(ys_full);
      end
   end

   always_comb begin
      if (yo_full < 0) begin
         value = '0;
      end else if (yo_full > OUT_MAX) begin
         value = SB'(OUT_MAX);
      end else begin
         value = yo_full[SB-1:0];
      end
   end

   always_comb begin
      yh0_in = yh0_ff;
      yh1_in = yh1_ff;
      if (ctl.step_clear) begin
         yh0_in = '0;
         yh1_in = '0;
      end else if (ctl.step_sample) begin
         yh0_in = ys_sat;
         yh1_in = yh0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xh0_ff <= '0;
         xh1_ff <= '0;
         yh0_ff <= '0;
         yh1_ff <= '0;
      end else begin
         xh0_ff <= xh0_in;
         xh1_ff <= xh1_in;
         yh0_ff <= yh0_in;
         yh1_ff <= yh1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_sample) begin
         pb0_ff <= pb0_in;
         pb1_ff <= pb1_in;
         pb2_ff <= pb2_in;
      end
   end

   `DBNF_ASSERT_NXT(a_y_cleared, clock, reset, ctl.step_clear, (yh0_ff == '0) && (yh1_ff == '0))
   `DBNF_ASSERT_NXT(a_x_cleared, clock, reset, ctl.load_clear, (xh0_ff == '0) && (xh1_ff == '0))
   `DBNF_ASSERT_NXT(a_y_shift, clock, reset, ctl.step_sample && !ctl.step_clear,
                    yh1_ff == $past(yh0_ff))

endmodule

`default_nettype wire

FILE: hw/rtl/dual_biquad_notch_filter.sv
// Dual biquad notch filter for a 12-bit ECG sample stream.
// Input channel req_*: one item per transfer. Action sample runs raw_sample through
// the recording and the live second-order section and gives one result; the two
// clear actions zero one path's history and give no result; the unused code is
// dropped. Result channel rsp_*: raw sample, both filtered values (rounded, clamped
// to the sample range) and the lead-off flags.
// Coefficients are written through csr_we/csr_index/csr_wdata; the user must write them only while
// the block is idle, as the block itself does not enforce this. An index with no register is ignored.
// Path: a sample transferred in is held in the stage register, then moves into the result
// register when that is free, and rsp_valid rises with it.
// Throughput: one item per cycle while the receiver keeps up. The limit is the feedback loop of the second
// stage: two coefficient-by-history multiplies, the sum, rounding and saturation.
// When the receiver stalls, the result register holds and one more item waits in
// the stage register; only then does req_ready fall.
// Synchronous reset empties both stages, zeroes all history and loads the default
// 50 Hz notch coefficients.
`default_nettype none

module dual_biquad_notch_filter #(
   parameter int COEF_FRAC_BITS  = 16,
   parameter int STATE_FRAC_BITS = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire dbnf_pkg::req_type                      req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output dbnf_pkg::rsp_type                           rsp_data,
   input  wire logic                                   csr_we,
   input  wire logic [dbnf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [COEF_FRAC_BITS+1:0]              csr_wdata
);

   `include "dual_biquad_notch_filter_assert.svh"

   localparam int  COEF_W = COEF_FRAC_BITS + 2;
   localparam int  SB     = dbnf_pkg::SAMPLE_BITS;
   localparam real SCALE  = 2.0 ** COEF_FRAC_BITS;

   localparam logic signed [COEF_W-1:0] RST_B0 = COEF_W'(int'(dbnf_pkg::NOTCH_B_OUTER * SCALE));
   localparam logic signed [COEF_W-1:0] RST_B1 = COEF_W'(int'(dbnf_pkg::NOTCH_B_MID * SCALE));
   localparam logic signed [COEF_W-1:0] RST_B2 = COEF_W'(int'(dbnf_pkg::NOTCH_B_OUTER * SCALE));
   localparam logic signed [COEF_W-1:0] RST_A1 = COEF_W'(int'(dbnf_pkg::NOTCH_A_ONE * SCALE));
   localparam logic signed [COEF_W-1:0] RST_A2 = COEF_W'(int'(dbnf_pkg::NOTCH_A_TWO * SCALE));

   logic signed [COEF_W-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;

   logic                    s1_valid_ff, s1_valid_in;
   logic [1:0]              s1_action_ff;
   logic [SB-1:0]           s1_raw_ff;
   logic                    s1_lop_ff, s1_lon_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   dbnf_pkg::rsp_type       rsp_ff, rsp_in;

   logic                    req_fire, req_known, s1_is_sample, s1_move, emit;
   dbnf_pkg::sec_ctl_type   rec_ctl, live_ctl;
   logic [SB-1:0]           rec_value, live_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= RST_B0;
         b1_ff <= RST_B1;
         b2_ff <= RST_B2;
         a1_ff <= RST_A1;
         a2_ff <= RST_A2;
      end else if (csr_we) begin
         unique case (csr_index)
            dbnf_pkg::CSR_COEF_B0: b0_ff <= $signed(csr_wdata);
            dbnf_pkg::CSR_COEF_B1: b1_ff <= $signed(csr_wdata);
            dbnf_pkg::CSR_COEF_B2: b2_ff <= $signed(csr_wdata);
            dbnf_pkg::CSR_COEF_A1: a1_ff <= $signed(csr_wdata);
            dbnf_pkg::CSR_COEF_A2: a2_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   assign req_known    = (req_data.action == dbnf_pkg::ACT_SAMPLE)
                      || (req_data.action == dbnf_pkg::ACT_CLEAR_REC)
                      || (req_data.action == dbnf_pkg::ACT_CLEAR_LIVE);
   assign s1_is_sample = s1_action_ff == dbnf_pkg::ACT_SAMPLE;
   // A clear needs no room in the result register.
   assign s1_move      = s1_valid_ff && (!s1_is_sample || !rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || s1_move;
   assign req_fire     = req_valid && req_ready;
   assign emit         = s1_move && s1_is_sample;

   always_comb begin
      rec_ctl.load_sample  = req_fire && (req_data.action == dbnf_pkg::ACT_SAMPLE);
      rec_ctl.load_clear   = req_fire && (req_data.action == dbnf_pkg::ACT_CLEAR_REC);
      rec_ctl.step_sample  = emit;
      rec_ctl.step_clear   = s1_move && (s1_action_ff == dbnf_pkg::ACT_CLEAR_REC);
      live_ctl.load_sample = rec_ctl.load_sample;
      live_ctl.load_clear  = req_fire && (req_data.action == dbnf_pkg::ACT_CLEAR_LIVE);
      live_ctl.step_sample = emit;
      live_ctl.step_clear  = s1_move && (s1_action_ff == dbnf_pkg::ACT_CLEAR_LIVE);
   end

   dbnf_section #(
      .COEF_FRAC_BITS  (COEF_FRAC_BITS),
      .STATE_FRAC_BITS (STATE_FRAC_BITS)
   ) u_rec (
      .clock   (clock),
      .reset   (reset),
      .ctl     (rec_ctl),
      .sample  (req_data.raw_sample),
      .coef_b0 (b0_ff),
      .coef_b1 (b1_ff),
      .coef_b2 (b2_ff),
      .coef_a1 (a1_ff),
      .coef_a2 (a2_ff),
      .value   (rec_value)
   );

   dbnf_section #(
      .COEF_FRAC_BITS  (COEF_FRAC_BITS),
      .STATE_FRAC_BITS (STATE_FRAC_BITS)
   ) u_live (
      .clock   (clock),
      .reset   (reset),
      .ctl     (live_ctl),
      .sample  (req_data.raw_sample),
      .coef_b0 (b0_ff),
      .coef_b1 (b1_ff),
      .coef_b2 (b2_ff),
      .coef_a1 (a1_ff),
      .coef_a2 (a2_ff),
      .value   (live_value)
   );

   always_comb begin
      if (req_fire && req_known) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_in.raw_echo         = s1_raw_ff;
      rsp_in.recording_value  = rec_value;
      rsp_in.live_value       = live_value;
      rsp_in.lead_off_pos_out = s1_lop_ff;
      rsp_in.lead_off_neg_out = s1_lon_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff <= req_data.action;
         s1_raw_ff    <= req_data.raw_sample;
         s1_lop_ff    <= req_data.lead_off_pos;
         s1_lon_ff    <= req_data.lead_off_neg;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DBNF_ASSERT_NXT(a_emit_shows, clock, reset, emit, rsp_valid_ff)
   `DBNF_ASSERT_IMP(a_full_blocks, clock, reset,
                    s1_valid_ff && s1_is_sample && rsp_valid_ff && !rsp_ready, !req_ready)
   `DBNF_ASSERT_NXT(a_clear_silent, clock, reset,
                    s1_move && !s1_is_sample && !rsp_valid_ff, !rsp_valid_ff)
   `DBNF_ASSERT_NXT(a_unused_dropped, clock, reset,
                    req_fire && !req_known && !s1_valid_ff, !s1_valid_ff)

endmodule

`default_nettype wire
